FILE: hw/rtl/ocd_pkg.sv
// ocd_pkg: shared types, codes and constants of the opcode id dictionary.
// Depends on nothing; each file of the block but ocd_queue refers to it by scope.
package ocd_pkg;

  localparam int SLOTS_DEF = 1024;
  localparam int OP_W      = 32;
  localparam int ID_W      = 11;
  localparam int Q_DEPTH   = 2;

  localparam logic [OP_W-1:0] HASH_MUL = 32'd2654435761;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_NEW     = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_CLEARED = 2'd3;

  localparam logic [ID_W-1:0] ID_FIRST = 11'd1;

  typedef struct packed {
    logic            command;
    logic [OP_W-1:0] opcode;
  } in_word_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [ID_W-1:0] id;
  } out_word_t;

  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
    logic [OP_W-1:0] opcode;
  } entry_t;

endpackage

FILE: hw/rtl/ocd_front.sv
// ocd_front: input register of the dictionary; takes words and hashes the opcode
// to its home slot. Depends on ocd_pkg.
module ocd_front #(
  parameter  int SLOTS = ocd_pkg::SLOTS_DEF,
  localparam int AW    = $clog2(SLOTS),
  localparam int QW    = 1 + ocd_pkg::OP_W + AW
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ocd_pkg::in_word_t in_word,
  output logic              push_valid,
  input  logic              push_ready,
  output logic [QW-1:0]     push_data
);

  logic                    f_valid_r, f_valid_nxt;
  logic                    f_cmd_r;
  logic [ocd_pkg::OP_W-1:0] f_op_r;
  logic [AW-1:0]           f_home_r;
  logic [AW-1:0]           op_lo;
  logic [AW-1:0]           mul_lo;
  logic [AW-1:0]           home_nxt;
  logic                    accept;

  assign op_lo    = in_word.opcode[AW-1:0];
  assign mul_lo   = ocd_pkg::HASH_MUL[AW-1:0];
  assign home_nxt = op_lo * mul_lo;

  assign in_stall   = f_valid_r && !push_ready;
  assign accept     = in_valid && !in_stall;
  assign push_valid = f_valid_r;
  assign push_data  = {f_cmd_r, f_op_r, f_home_r};

  always_comb begin
    f_valid_nxt = f_valid_r;
    if (accept) begin
      f_valid_nxt = 1'b1;
    end else if (f_valid_r && push_ready) begin
      f_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_cmd_r  <= in_word.command;
      f_op_r   <= in_word.opcode;
      f_home_r <= home_nxt;
    end
  end

endmodule

FILE: hw/rtl/ocd_queue.sv
// ocd_queue: short FIFO between the front and the back of the dictionary.
// Depends on nothing.
module ocd_queue #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [IW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [IW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == IW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == IW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/ocd_back.sv
// ocd_back: probe engine of the dictionary; owns the slot memory, the id counter,
// the clearing sweep and the output register. Depends on ocd_pkg.
module ocd_back #(
  parameter  int SLOTS = ocd_pkg::SLOTS_DEF,
  localparam int AW    = $clog2(SLOTS),
  localparam int QW    = 1 + ocd_pkg::OP_W + AW
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  logic [QW-1:0]      pop_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ocd_pkg::out_word_t out_word
);

  typedef enum logic [2:0] {
    S_SWEEP = 3'b001,
    S_IDLE  = 3'b010,
    S_PROBE = 3'b100
  } bstate_t;

  ocd_pkg::entry_t mem [SLOTS];
  ocd_pkg::entry_t rd_data_r;
  ocd_pkg::entry_t wr_data;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [AW-1:0]   rd_addr;

  bstate_t                   state_r, state_nxt;
  logic [AW-1:0]             sweep_r, sweep_nxt;
  logic [AW-1:0]             probe_r, probe_nxt;
  logic [AW-1:0]             idx_r, idx_nxt;
  logic [ocd_pkg::OP_W-1:0]  op_r, op_nxt;
  logic [ocd_pkg::ID_W-1:0]  next_id_r, next_id_nxt;
  logic                      clr_pend_r, clr_pend_nxt;
  logic                      out_valid_r, out_valid_nxt;
  ocd_pkg::out_word_t        out_word_r, out_word_nxt;

  logic                      q_cmd;
  logic [ocd_pkg::OP_W-1:0]  q_op;
  logic [AW-1:0]             q_home;
  logic                      take;

  assign {q_cmd, q_op, q_home} = pop_data;
  assign pop_ready = (state_r == S_IDLE) && !out_valid_r;
  assign take      = pop_valid && pop_ready;
  assign rd_addr   = (state_r == S_IDLE) ? q_home : idx_r + 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    state_nxt     = state_r;
    sweep_nxt     = sweep_r;
    probe_nxt     = probe_r;
    idx_nxt       = idx_r;
    op_nxt        = op_r;
    next_id_nxt   = next_id_r;
    clr_pend_nxt  = clr_pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = '{valid: 1'b1, id: next_id_r, opcode: op_r};
    unique case (state_r)
      S_SWEEP: begin
        wr_en     = 1'b1;
        wr_addr   = sweep_r;
        wr_data   = '0;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == AW'(SLOTS - 1)) begin
          state_nxt    = S_IDLE;
          clr_pend_nxt = 1'b0;
          if (clr_pend_r) begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{status: ocd_pkg::ST_CLEARED, id: '0};
          end
        end
      end
      S_IDLE: begin
        if (take) begin
          if (q_cmd == ocd_pkg::CMD_CLEAR) begin
            state_nxt    = S_SWEEP;
            sweep_nxt    = '0;
            clr_pend_nxt = 1'b1;
            next_id_nxt  = ocd_pkg::ID_FIRST;
          end else begin
            state_nxt = S_PROBE;
            idx_nxt   = q_home;
            op_nxt    = q_op;
            probe_nxt = '0;
          end
        end
      end
      S_PROBE: begin
        if (!rd_data_r.valid) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (next_id_r == '0) begin
            out_word_nxt = '{status: ocd_pkg::ST_FULL, id: '0};
          end else begin
            wr_en        = 1'b1;
            next_id_nxt  = next_id_r + 1'b1;
            out_word_nxt = '{status: ocd_pkg::ST_NEW, id: next_id_r};
          end
        end else if (rd_data_r.opcode == op_r) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{status: ocd_pkg::ST_FOUND, id: rd_data_r.id};
        end else if (probe_r == AW'(SLOTS - 1)) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{status: ocd_pkg::ST_FULL, id: '0};
        end else begin
          idx_nxt   = idx_r + 1'b1;
          probe_nxt = probe_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      sweep_r     <= '0;
      next_id_r   <= ocd_pkg::ID_FIRST;
      clr_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      next_id_r   <= next_id_nxt;
      clr_pend_r  <= clr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    probe_r    <= probe_nxt;
    idx_r      <= idx_nxt;
    op_r       <= op_nxt;
    out_word_r <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

FILE: hw/rtl/opcode_id_dictionary.sv
// opcode_id_dictionary: top level; front hash stage, word queue and probe engine.
// Depends on ocd_pkg, ocd_front, ocd_queue and ocd_back.
//
// Maps 32-bit opcodes to dense ids counting from 1 in an open-addressed table of
// SLOTS entries (power of two) with linear probing; the home slot is the low bits
// of opcode * 2654435761. Words are taken into a hash register and a two-word
// queue while the probe engine works, so the input keeps flowing while a result
// waits. A lookup holds the probe engine while it reads its home slot and each
// slot that it steps past, and while its result word is stalled: the single
// read port of the slot memory reads one slot per cycle, and the engine takes
// the next word only once the result word has left. After reset, and for every
// clear word, the engine sweeps the whole memory and runs no lookup meanwhile;
// the cleared result appears at the end of that sweep.
module opcode_id_dictionary #(
  parameter int SLOTS = ocd_pkg::SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ocd_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output ocd_pkg::out_word_t out_word
);

  localparam int AW = $clog2(SLOTS);
  localparam int QW = 1 + ocd_pkg::OP_W + AW;

  logic          push_valid, push_ready;
  logic [QW-1:0] push_data;
  logic          pop_valid, pop_ready;
  logic [QW-1:0] pop_data;

  ocd_front #(.SLOTS(SLOTS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  ocd_queue #(.DEPTH(ocd_pkg::Q_DEPTH), .WIDTH(QW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  ocd_back #(.SLOTS(SLOTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

FILE: hw/rtl/ocd_checker.sv
// ocd_checker: port-level assertions for opcode_id_dictionary, bound to the top.
// Depends on ocd_pkg.
module ocd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input ocd_pkg::in_word_t  in_word,
  input logic               out_valid,
  input logic               out_stall,
  input ocd_pkg::out_word_t out_word
);

  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !$isunknown(in_word))
    else $error("accepted input word has unknown bits");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  a_id_given: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status == ocd_pkg::ST_FOUND ||
                  out_word.status == ocd_pkg::ST_NEW)
    |-> out_word.id != '0)
    else $error("found or new result carries id zero");

  a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status == ocd_pkg::ST_FULL ||
                  out_word.status == ocd_pkg::ST_CLEARED)
    |-> out_word.id == '0)
    else $error("full or cleared result carries nonzero id");

  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result word right after reset");

endmodule

bind opcode_id_dictionary ocd_checker u_ocd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

FILE: tb/tb_opcode_id_dictionary.sv
`timescale 1ns / 100ps
// Testbench for opcode_id_dictionary: directed and random traffic checked
// against an in-order hash table predictor. Depends on ocd_pkg and the dictionary RTL.
module tb_opcode_id_dictionary;

  localparam int TBL_SLOTS   = ocd_pkg::SLOTS_DEF;
  localparam int CYCLE_LIMIT = 8_000_000;

  class opcode_dict_scoreboard;
    bit                       used      [TBL_SLOTS];
    logic [ocd_pkg::OP_W-1:0] slot_key  [TBL_SLOTS];
    logic [ocd_pkg::ID_W-1:0] slot_id   [TBL_SLOTS];
    logic [ocd_pkg::ID_W-1:0] next_id;
    int                       errors;
    ocd_pkg::out_word_t       pending_q[$];

    function new();
      wipe();
      errors = 0;
    endfunction

    function void wipe();
      for (int i = 0; i < TBL_SLOTS; i++) used[i] = 1'b0;
      next_id = ocd_pkg::ID_FIRST;
    endfunction

    function int home_slot(logic [ocd_pkg::OP_W-1:0] op);
      logic [ocd_pkg::OP_W-1:0] prod;
      prod = op * ocd_pkg::HASH_MUL;
      return int'(prod & ocd_pkg::OP_W'(TBL_SLOTS - 1));
    endfunction

    // accepted input word: walk the table and queue the result it must produce
    function void note_word(ocd_pkg::in_word_t w);
      ocd_pkg::out_word_t res;
      int                 idx;
      res.status = ocd_pkg::ST_FULL;
      res.id     = '0;
      if (w.command == ocd_pkg::CMD_CLEAR) begin
        wipe();
        res.status = ocd_pkg::ST_CLEARED;
      end else begin
        idx = home_slot(w.opcode);
        for (int n = 0; n < TBL_SLOTS; n++) begin
          if (!used[idx]) begin
            if (next_id != '0) begin
              used[idx]     = 1'b1;
              slot_key[idx] = w.opcode;
              slot_id[idx]  = next_id;
              res.status    = ocd_pkg::ST_NEW;
              res.id        = next_id;
              next_id       = next_id + 1'b1;
            end
            break;
          end
          if (slot_key[idx] == w.opcode) begin
            res.status = ocd_pkg::ST_FOUND;
            res.id     = slot_id[idx];
            break;
          end
          idx = (idx + 1) & (TBL_SLOTS - 1);
        end
      end
      pending_q.push_back(res);
    endfunction

    function void check_word(ocd_pkg::out_word_t got);
      ocd_pkg::out_word_t want;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: status=%0d id=%0d",
                 $time, got.status, got.id);
        return;
      end
      want = pending_q.pop_front();
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d actual %0d", $time,
                 want.status, got.status);
      end
      if (got.id !== want.id) begin
        errors++;
        $display("%0t: id mismatch: expected %0d actual %0d", $time, want.id, got.id);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  ocd_pkg::in_word_t  in_word   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  ocd_pkg::out_word_t out_word;

  opcode_dict_scoreboard    dict = new();
  logic [ocd_pkg::OP_W-1:0] seen_ops[$];
  bit                       tx_calm = 1'b0;
  bit                       rx_calm = 1'b0;
  int                       rx_wait = 0;
  int                       cycle_count = 0;

  opcode_id_dictionary #(.SLOTS(TBL_SLOTS)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: random stall per word, none while rx_calm is set
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      dict.check_word(out_word);
      rx_wait = rx_calm ? 0 : $urandom_range(0, 7);
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    out_stall <= (rx_wait > 0);
  end

  task automatic send_word(input logic cmd, input logic [ocd_pkg::OP_W-1:0] op);
    ocd_pkg::in_word_t w;
    int                gap;
    w.command = cmd;
    w.opcode  = op;
    gap = tx_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    dict.note_word(w);
    if (cmd == ocd_pkg::CMD_LOOKUP) begin
      seen_ops.push_back(op);
      if (seen_ops.size() > 512) void'(seen_ops.pop_front());
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (dict.pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic run_mixed(input int count);
    int                       pick;
    logic [ocd_pkg::OP_W-1:0] op;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        tx_calm = ($urandom_range(0, 2) == 0);
        rx_calm = ($urandom_range(0, 2) == 0);
      end
      pick = $urandom_range(0, 99);
      op   = $urandom;
      if (pick < 2) begin
        if ($urandom_range(0, 1) == 1) drain_results();
        send_word(ocd_pkg::CMD_CLEAR, op);
      end else begin
        if (pick < 45 && seen_ops.size() > 0)
          op = seen_ops[$urandom_range(0, seen_ops.size() - 1)];
        else if (pick < 60 && seen_ops.size() > 0)
          op = seen_ops[$urandom_range(0, seen_ops.size() - 1)] +
               ocd_pkg::OP_W'(TBL_SLOTS * $urandom_range(1, 3));
        else if (pick < 65)
          op = 32'h1 << $urandom_range(0, 31);
        else if (pick < 70)
          op = ~(32'h1 << $urandom_range(0, 31));
        send_word(ocd_pkg::CMD_LOOKUP, op);
      end
    end
  endtask

  initial begin
    logic [ocd_pkg::OP_W-1:0] wrap_op;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, collisions, wrap at the top slot, clears
    wrap_op = '0;
    while (dict.home_slot(wrap_op) != TBL_SLOTS - 1) wrap_op++;
    send_word(ocd_pkg::CMD_LOOKUP, 32'h0000_0000);
    send_word(ocd_pkg::CMD_LOOKUP, 32'hFFFF_FFFF);
    send_word(ocd_pkg::CMD_LOOKUP, 32'h0000_0000);
    send_word(ocd_pkg::CMD_LOOKUP, 32'h8000_0000);
    send_word(ocd_pkg::CMD_LOOKUP, 32'h0000_0001);
    send_word(ocd_pkg::CMD_LOOKUP, 32'hAAAA_AAAA);
    send_word(ocd_pkg::CMD_LOOKUP, 32'h5555_5555);
    for (int k = 0; k < 4; k++)
      send_word(ocd_pkg::CMD_LOOKUP, wrap_op + ocd_pkg::OP_W'(k * TBL_SLOTS));
    send_word(ocd_pkg::CMD_LOOKUP, wrap_op + ocd_pkg::OP_W'(3 * TBL_SLOTS));
    send_word(ocd_pkg::CMD_LOOKUP, ocd_pkg::OP_W'(TBL_SLOTS));
    send_word(ocd_pkg::CMD_LOOKUP, ocd_pkg::OP_W'(2 * TBL_SLOTS));
    drain_results();
    send_word(ocd_pkg::CMD_CLEAR, 32'hFFFF_FFFF);
    send_word(ocd_pkg::CMD_LOOKUP, 32'hFFFF_FFFF);
    send_word(ocd_pkg::CMD_CLEAR, 32'h0000_0000);
    send_word(ocd_pkg::CMD_CLEAR, 32'h1234_5678);
    send_word(ocd_pkg::CMD_LOOKUP, 32'h1234_5678);

    run_mixed(340);

    drain_results();
    send_word(ocd_pkg::CMD_CLEAR, $urandom);

    run_mixed(340);

    in_valid <= 1'b0;
    while (dict.pending_q.size() != 0) @(posedge clk);
    repeat (TBL_SLOTS + 16) @(posedge clk);
    if (dict.errors == 0 && dict.pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
